@@ src/sgp_pkg.sv @@
`timescale 1ns / 1ps

package sgp_pkg;

  // Field widths
  localparam int NODE_W      = 13;
  localparam int POS_W       = 16;
  localparam int SEG_LEN_W   = 10;
  localparam int CHAN_W      = 8;
  localparam int CHANNELS    = 3;
  localparam int PROD_W      = SEG_LEN_W + CHAN_W;
  localparam int DIV_STEPS   = CHAN_W;
  localparam int COUNT_W     = 3;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = SEG_LEN_W + CHANNELS * CHAN_W;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEGMENT_COUNT = 4'd0,
    REG_STRIP_LENGTH  = 4'd1,
    REG_SEGMENT_0     = 4'd2
  } cfg_reg_t;

  // Channel 2 is red, 1 green, 0 blue, matching the register packing
  typedef logic [CHANNELS-1:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic                 we;
    logic [POS_W-1:0]     pos;
    logic                 blank;
    logic [SEG_LEN_W-1:0] len;
    logic [CHANNELS-1:0]  up;
    rgb_t                 src;
  } ctx_t;

  typedef struct packed {
    logic [SEG_LEN_W-1:0] rem;
    logic [CHAN_W-1:0]    low;
    logic [CHAN_W-1:0]    quo;
  } div_lane_t;

  typedef struct packed {
    ctx_t                       ctx;
    div_lane_t [CHANNELS-1:0]   lane;
  } pipe_t;

  // One restoring division step: bring down one numerator bit, settle one quotient bit
  function automatic div_lane_t div_step(div_lane_t d, logic [SEG_LEN_W-1:0] len);
    logic [SEG_LEN_W:0] t;
    div_lane_t          r;
    t     = {d.rem, d.low[CHAN_W-1]};
    r.low = {d.low[CHAN_W-2:0], 1'b0};
    if (t >= {1'b0, len}) begin
      r.rem = SEG_LEN_W'(t - {1'b0, len});
      r.quo = {d.quo[CHAN_W-2:0], 1'b1};
    end else begin
      r.rem = t[SEG_LEN_W-1:0];
      r.quo = {d.quo[CHAN_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ src/sgp_in_if.sv @@
`timescale 1ns / 1ps

interface sgp_in_if;
  import sgp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NODE_W-1:0]       node_index;
  logic signed [POS_W-1:0] offset;
  logic                    decay_bit;

  modport source (output valid, output node_index, output offset, output decay_bit,
                  input ready);
  modport sink   (input valid, input node_index, input offset, input decay_bit,
                  output ready);
endinterface

@@ src/sgp_out_if.sv @@
`timescale 1ns / 1ps

interface sgp_out_if;
  import sgp_pkg::*;

  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [POS_W-1:0]  position;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output write_enable, output position, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input write_enable, input position, input red,
                  input green, input blue, output ready);
endinterface

@@ src/segmented_gradient_pixel_generator_top.sv @@
`timescale 1ns / 1ps

// Segmented gradient pixel generator. Each item names one node of a chain of
// colour segments plus a strip offset and a decay bit; the block returns one
// pixel item: strip position, RGB and a write flag. The colour blends
// linearly from the segment's colour towards the next segment's colour (or
// black after the last segment in use), truncating the division by the
// segment length. Throughput is one item per clock unless the output stalls.
// An item passes through twelve registers: input register, segment lookup,
// channel difference and multiply, eight stages of a restoring divider (one
// quotient bit per stage, three channels side by side) and the output
// register. The input register loads at the accepting edge. The stages hold
// in place on back-pressure and collapse bubbles, so the input keeps taking
// items while a result waits.
// Write the configuration registers only while no item is in flight.
module segmented_gradient_pixel_generator_top #(
  parameter int MAX_SEGMENTS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic [sgp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sgp_pkg::CFG_DATA_W-1:0]   cfg_data,
  sgp_in_if.sink                           pixel_in,
  sgp_out_if.source                        pixel_out
);
  import sgp_pkg::*;

  localparam logic [COUNT_W-1:0] SEG_LIMIT = COUNT_W'(MAX_SEGMENTS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]    segment_count;
  logic [POS_W-1:0]      strip_length;
  logic [CFG_DATA_W-1:0] segment [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      strip_length  <= '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        segment[k] <= '0;
      end
    end else if (cfg_write_enable) begin
      if (cfg_index == REG_SEGMENT_COUNT) begin
        segment_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_index == REG_STRIP_LENGTH) begin
        strip_length <= cfg_data[POS_W-1:0];
      end
      // Indices past the last segment fall through untouched
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        if (cfg_index == CFG_INDEX_W'(int'(REG_SEGMENT_0) + k)) begin
          segment[k] <= cfg_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segment end table, rebuilt from the registers every cycle. A count above
  // the segment limit counts as the limit; segments past the count are unused.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]      count_clamped;
  logic [NODE_W-1:0]       seg_acc;
  logic [NODE_W-1:0]       seg_end_next [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_used_next;
  logic [NODE_W-1:0]       seg_end [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] seg_used;

  always_comb begin
    count_clamped = (segment_count > SEG_LIMIT) ? SEG_LIMIT : segment_count;
    seg_acc       = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_acc          = seg_acc + NODE_W'(segment[k][CFG_DATA_W-1 -: SEG_LEN_W]);
      seg_end_next[k]  = seg_acc;
      seg_used_next[k] = (COUNT_W'(k) < count_clamped);
    end
  end

  always_ff @(posedge clk) begin
    seg_end  <= seg_end_next;
    seg_used <= seg_used_next;
  end

  // ---------------------------------------------------------------------------
  // Stall control: each stage advances when it is empty or the next one moves
  // ---------------------------------------------------------------------------
  logic                 s1_valid;
  logic                 s2_valid;
  logic [DIV_STEPS:0]   stg_valid;
  logic                 o_valid;
  logic                 o_ready;
  logic [DIV_STEPS:0]   stg_ready;
  logic                 s2_ready;
  logic                 s1_ready;

  always_comb begin
    o_ready              = !o_valid || pixel_out.ready;
    stg_ready[DIV_STEPS] = !stg_valid[DIV_STEPS] || o_ready;
    for (int j = DIV_STEPS - 1; j >= 0; j--) begin
      stg_ready[j] = !stg_valid[j] || stg_ready[j+1];
    end
    s2_ready = !s2_valid || stg_ready[0];
    s1_ready = !s1_valid || s2_ready;
  end

  // Refuse items while reset is held so none is taken and then lost
  assign pixel_in.ready = s1_ready && !rst;

  // ---------------------------------------------------------------------------
  // Stage 1: register the item and form the strip position
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0]  s1_node;
  logic [POS_W:0]     s1_pos;
  logic               s1_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_node  <= pixel_in.node_index;
      s1_pos   <= {pixel_in.offset[POS_W-1], pixel_in.offset} +
                  (POS_W + 1)'(pixel_in.node_index);
      s1_decay <= pixel_in.decay_bit;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: find the segment holding the node. Ends rise monotonically, so
  // the first used segment whose end lies past the node is the one; empty
  // segments can never be picked that way but still lend their colour.
  // ---------------------------------------------------------------------------
  logic [MAX_SEGMENTS-1:0] seg_lt;
  logic [MAX_SEGMENTS-1:0] seg_sel;
  logic [SEG_LEN_W-1:0]    lk_local;
  logic [SEG_LEN_W-1:0]    lk_len;
  rgb_t                    lk_src;
  rgb_t                    lk_dst;
  logic                    lk_we;

  always_comb begin
    lk_local = '0;
    lk_len   = '0;
    lk_src   = '0;
    lk_dst   = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_lt[k] = seg_used[k] && (s1_node < seg_end[k]);
    end
    seg_sel[0] = seg_lt[0];
    for (int k = 1; k < MAX_SEGMENTS; k++) begin
      seg_sel[k] = seg_lt[k] && !seg_lt[k-1];
    end
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (seg_sel[k]) begin
        lk_local = (k == 0) ? SEG_LEN_W'(s1_node)
                            : SEG_LEN_W'(s1_node - seg_end[(k == 0) ? 0 : k-1]);
        lk_len   = lk_len | segment[k][CFG_DATA_W-1 -: SEG_LEN_W];
        lk_src   = lk_src | rgb_t'(segment[k][CHANNELS*CHAN_W-1:0]);
      end
      // Destination is the next used segment, or black past the last one
      if (k > 0 && seg_sel[(k == 0) ? 0 : k-1] && seg_used[k]) begin
        lk_dst = lk_dst | rgb_t'(segment[k][CHANNELS*CHAN_W-1:0]);
      end
    end
    lk_we = (|seg_lt) && !s1_pos[POS_W] && (s1_pos[POS_W-1:0] < strip_length);
  end

  logic                 s2_we;
  logic [POS_W-1:0]     s2_pos;
  logic                 s2_blank;
  logic [SEG_LEN_W-1:0] s2_local;
  logic [SEG_LEN_W-1:0] s2_len;
  rgb_t                 s2_src;
  rgb_t                 s2_dst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_we    <= lk_we;
      s2_pos   <= s1_pos[POS_W-1:0];
      s2_blank <= s1_decay && seg_sel[0];
      s2_local <= lk_local;
      s2_len   <= lk_len;
      s2_src   <= lk_src;
      s2_dst   <= lk_dst;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per channel, take the difference towards the destination and
  // scale it by the node's place in the segment. The product stays below
  // len * 256, so the top bits seed the divider remainder.
  // ---------------------------------------------------------------------------
  pipe_t                     stg_in;
  logic [CHAN_W-1:0]         mul_diff [CHANNELS];
  logic [PROD_W-1:0]         mul_prod [CHANNELS];

  always_comb begin
    stg_in.ctx.we    = s2_we;
    stg_in.ctx.pos   = s2_pos;
    stg_in.ctx.blank = s2_blank;
    stg_in.ctx.len   = s2_len;
    stg_in.ctx.src   = s2_src;
    for (int c = 0; c < CHANNELS; c++) begin
      stg_in.ctx.up[c]   = (s2_src[c] < s2_dst[c]);
      mul_diff[c]        = stg_in.ctx.up[c] ? (s2_dst[c] - s2_src[c])
                                            : (s2_src[c] - s2_dst[c]);
      mul_prod[c]        = PROD_W'(s2_local) * PROD_W'(mul_diff[c]);
      stg_in.lane[c].rem = mul_prod[c][PROD_W-1:CHAN_W];
      stg_in.lane[c].low = mul_prod[c][CHAN_W-1:0];
      stg_in.lane[c].quo = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 register and divider stages: one quotient bit per stage
  // ---------------------------------------------------------------------------
  pipe_t stg [DIV_STEPS+1];
  pipe_t stg_next [DIV_STEPS+1];

  always_comb begin
    stg_next[0] = stg_in;
    for (int j = 0; j < DIV_STEPS; j++) begin
      stg_next[j+1].ctx = stg[j].ctx;
      for (int c = 0; c < CHANNELS; c++) begin
        stg_next[j+1].lane[c] = div_step(stg[j].lane[c], stg[j].ctx.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (stg_ready[0]) begin
        stg_valid[0] <= s2_valid;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (stg_ready[j+1]) begin
          stg_valid[j+1] <= stg_valid[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= DIV_STEPS; j++) begin
      if (stg_ready[j]) begin
        stg[j] <= stg_next[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: apply the quotient, blank decayed pixels of the first segment, zero the
  // fields of pixels that are not written
  // ---------------------------------------------------------------------------
  rgb_t             o_rgb_next;
  logic             o_we;
  logic [POS_W-1:0] o_pos;
  rgb_t             o_rgb;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (!stg[DIV_STEPS].ctx.we || stg[DIV_STEPS].ctx.blank) begin
        o_rgb_next[c] = '0;
      end else if (stg[DIV_STEPS].ctx.up[c]) begin
        o_rgb_next[c] = stg[DIV_STEPS].ctx.src[c] + stg[DIV_STEPS].lane[c].quo;
      end else begin
        o_rgb_next[c] = stg[DIV_STEPS].ctx.src[c] - stg[DIV_STEPS].lane[c].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= stg_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      o_we  <= stg[DIV_STEPS].ctx.we;
      o_pos <= stg[DIV_STEPS].ctx.we ? stg[DIV_STEPS].ctx.pos : '0;
      o_rgb <= o_rgb_next;
    end
  end

  assign pixel_out.valid        = o_valid;
  assign pixel_out.write_enable = o_we;
  assign pixel_out.position     = o_pos;
  assign pixel_out.red          = o_rgb[2];
  assign pixel_out.green        = o_rgb[1];
  assign pixel_out.blue         = o_rgb[0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The segment lookup picks at most one segment
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(seg_sel))
    else $error("segment lookup selected more than one segment");

  // The divider remainder stays below the segment length on written pixels
  generate
    for (genvar j = 0; j <= DIV_STEPS; j++) begin : g_rem_chk
      a_rem_bound: assert property (@(posedge clk) disable iff (rst)
        (stg_valid[j] && stg[j].ctx.we) |->
          (stg[j].lane[0].rem < stg[j].ctx.len) &&
          (stg[j].lane[1].rem < stg[j].ctx.len) &&
          (stg[j].lane[2].rem < stg[j].ctx.len))
        else $error("divider remainder out of range");
    end
  endgenerate

  // A written pixel always lands inside the strip
  a_pos_in_strip: assert property (@(posedge clk) disable iff (rst)
    (pixel_out.valid && pixel_out.write_enable) |-> (pixel_out.position < strip_length))
    else $error("written pixel outside the strip");

  // No item is taken while reset is held
  a_no_take_in_reset: assert property (@(posedge clk)
    rst |-> !pixel_in.ready)
    else $error("input ready during reset");

endmodule
